FILE: rtl/obc_pkg.sv
// shared types, constants and cordic step for the oriented box corner block
`default_nettype none

package obc_pkg;

    localparam int          CORDIC_STEPS   = 24;
    localparam int          ITER_PER_STAGE = 4;
    localparam int          CORDIC_STAGES  = CORDIC_STEPS / ITER_PER_STAGE;
    localparam int          ANGLE_BITS_DEF = 16;
    localparam logic [15:0] EXTENT_RESET   = 16'd6554;
    localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;
    localparam logic [1:0]  LAST_CORNER    = 2'd3;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic        [15:0] angle;
    } t_obc_in;

    typedef struct packed {
        logic        [1:0]  corner_index;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic               last_corner;
    } t_obc_out;

    // per-item values that ride alongside the cordic
    typedef struct packed {
        logic signed [31:0] h;
        logic signed [31:0] v;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_obc_side;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_obc_rot;

    function automatic t_obc_rot cordic_step(t_obc_rot st, int i);
        t_obc_rot           res;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] at;
        dx = $signed(st.y) >>> i;
        dy = $signed(st.x) >>> i;
        at = $signed(ATAN_TURNS[i]);
        if (!st.z[31]) begin
            res.x = st.x - dx;
            res.y = st.y + dy;
            res.z = st.z - at;
        end else begin
            res.x = st.x + dx;
            res.y = st.y - dy;
            res.z = st.z + at;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/obc_cordic.sv
// pipelined rotation-mode cordic giving clamped sine and cosine per item
`default_nettype none

module obc_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_turn,
    input  wire obc_pkg::t_obc_side i_side,
    output logic                   o_valid,
    output logic signed [31:0]     o_cos,
    output logic signed [31:0]     o_sin,
    output obc_pkg::t_obc_side     o_side
);
    import obc_pkg::*;

    typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} t_quad;

    localparam logic signed [31:0] UNIT = 32'sd1073741824;

    logic [CORDIC_STAGES-1:0] r_vld;
    t_obc_rot                 r_rot  [CORDIC_STAGES];
    t_obc_rot                 n_rot  [CORDIC_STAGES];
    t_quad                    r_quad [CORDIC_STAGES];
    t_obc_side                r_side [CORDIC_STAGES];

    logic                     r_out_vld;
    logic signed [31:0]       r_cos;
    logic signed [31:0]       r_sin;
    t_obc_side                r_out_side;

    logic signed [31:0]       n_cos;
    logic signed [31:0]       n_sin;

    function automatic logic signed [31:0] clamp_unit(logic signed [31:0] v);
        if (v > UNIT) begin
            return UNIT;
        end else if (v < -UNIT) begin
            return -UNIT;
        end
        return v;
    endfunction

    always_comb begin
        t_obc_rot st;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (k == 0) begin
                st.x = $signed(CORDIC_GAIN);
                st.y = '0;
                st.z = {2'b00, i_turn[29:0]};
            end else begin
                st = r_rot[k-1];
            end
            for (int j = 0; j < ITER_PER_STAGE; j++) begin
                st = cordic_step(st, k * ITER_PER_STAGE + j);
            end
            n_rot[k] = st;
        end
    end

    // quadrant fold by swap and negate
    always_comb begin
        case (r_quad[CORDIC_STAGES-1])
            Q_FIRST: begin
                n_cos = r_rot[CORDIC_STAGES-1].x;
                n_sin = r_rot[CORDIC_STAGES-1].y;
            end
            Q_SECOND: begin
                n_cos = -r_rot[CORDIC_STAGES-1].y;
                n_sin = r_rot[CORDIC_STAGES-1].x;
            end
            Q_THIRD: begin
                n_cos = -r_rot[CORDIC_STAGES-1].x;
                n_sin = -r_rot[CORDIC_STAGES-1].y;
            end
            default: begin
                n_cos = r_rot[CORDIC_STAGES-1].y;
                n_sin = -r_rot[CORDIC_STAGES-1].x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[CORDIC_STAGES-2:0], i_valid};
            r_out_vld <= r_vld[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_rot[k] <= n_rot[k];
                if (k == 0) begin
                    r_quad[k] <= t_quad'(i_turn[31:30]);
                    r_side[k] <= i_side;
                end else begin
                    r_quad[k] <= r_quad[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
            r_cos      <= clamp_unit(n_cos);
            r_sin      <= clamp_unit(n_sin);
            r_out_side <= r_side[CORDIC_STAGES-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_side  = r_out_side;

endmodule

`default_nettype wire

FILE: rtl/oriented_box_corners.sv
// top level: corners of a scaled, rotated rectangle, four beats per item
//
//  channel   valid     stall     payload      beats per item
//  input     i_valid   o_stall   i_item       1
//  output    o_valid   i_stall   o_corner     4 (last_corner on the fourth)
//  config    i_cfg_we  -         i_cfg_data   write only
//
// the serialiser sends one corner per cycle while the output is not stalled, and
// takes a new item only with the last corner of the one before; the first corner passes
// the input stage, six cordic stages, fold, multiply, serialiser and two corner stages.
// reset is synchronous and clears valid bits, the serialiser count and extent_factor.
// a stall on a valid output freezes every stage; the item side advances only when
// the serialiser is loading a new item.
`default_nettype none

module oriented_box_corners #(
    parameter int ANGLE_BITS = obc_pkg::ANGLE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire obc_pkg::t_obc_in i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output obc_pkg::t_obc_out    o_corner
);
    import obc_pkg::*;

    localparam logic [31:0] ANGLE_KEEP =
        32'(~((64'd1 << (32 - ANGLE_BITS)) - 64'd1));

    logic               en;
    logic               take;

    logic [15:0]        r_extent_factor;

    // input stage
    logic               r_in_valid;
    t_obc_side          r_in_side;
    logic [31:0]        r_in_turn;
    logic signed [48:0] n_h_prod;
    logic signed [48:0] n_v_prod;

    // cordic outputs
    logic               cd_valid;
    logic signed [31:0] cd_cos;
    logic signed [31:0] cd_sin;
    t_obc_side          cd_side;

    // multiply stage
    logic               r_m_valid;
    logic signed [63:0] r_hc;
    logic signed [63:0] r_hs;
    logic signed [63:0] r_vc;
    logic signed [63:0] r_vs;
    logic signed [31:0] r_m_px;
    logic signed [31:0] r_m_py;

    // corner serialiser
    logic               r_g_valid;
    logic [1:0]         r_g_cnt;
    logic signed [63:0] r_g_hc;
    logic signed [63:0] r_g_hs;
    logic signed [63:0] r_g_vc;
    logic signed [63:0] r_g_vs;
    logic signed [31:0] r_g_px;
    logic signed [31:0] r_g_py;

    // corner rotate stage
    logic               r_c1_valid;
    logic [1:0]         r_c1_idx;
    logic signed [34:0] r_c1_rx;
    logic signed [34:0] r_c1_ry;
    logic signed [31:0] r_c1_px;
    logic signed [31:0] r_c1_py;
    logic signed [64:0] n_sum_x;
    logic signed [64:0] n_sum_y;

    // output register
    logic               r_out_valid;
    t_obc_out           r_out;
    logic signed [35:0] n_ox;
    logic signed [35:0] n_oy;

    assign en      = !r_out_valid || !i_stall;
    assign take    = en && (!r_g_valid || r_g_cnt == LAST_CORNER);
    assign o_stall = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent_factor <= EXTENT_RESET;
        end else if (i_cfg_we) begin
            r_extent_factor <= i_cfg_data;
        end
    end

    assign n_h_prod = $signed(i_item.scale_x) * $signed({1'b0, r_extent_factor});
    assign n_v_prod = $signed(i_item.scale_y) * $signed({1'b0, r_extent_factor});

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_side.h  <= n_h_prod[47:16];
            r_in_side.v  <= n_v_prod[47:16];
            r_in_side.px <= i_item.pos_x;
            r_in_side.py <= i_item.pos_y;
            r_in_turn    <= {i_item.angle, 16'h0000} & ANGLE_KEEP;
        end
    end

    obc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (take),
        .i_valid (r_in_valid),
        .i_turn  (r_in_turn),
        .i_side  (r_in_side),
        .o_valid (cd_valid),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin),
        .o_side  (cd_side)
    );

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hc   <= cd_side.h * cd_cos;
            r_hs   <= cd_side.h * cd_sin;
            r_vc   <= cd_side.v * cd_cos;
            r_vs   <= cd_side.v * cd_sin;
            r_m_px <= cd_side.px;
            r_m_py <= cd_side.py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_g_hc <= r_hc;
            r_g_hs <= r_hs;
            r_g_vc <= r_vc;
            r_g_vs <= r_vs;
            r_g_px <= r_m_px;
            r_g_py <= r_m_py;
        end
    end

    // x sign is negative on corners 0 and 3, y sign on corners 0 and 1
    always_comb begin
        logic signed [64:0] hc;
        logic signed [64:0] hs;
        logic signed [64:0] vc;
        logic signed [64:0] vs;
        hc = 65'(r_g_hc);
        hs = 65'(r_g_hs);
        vc = 65'(r_g_vc);
        vs = 65'(r_g_vs);
        if (r_g_cnt[0] == r_g_cnt[1]) begin
            hc = -hc;
            hs = -hs;
        end
        if (!r_g_cnt[1]) begin
            vc = -vc;
            vs = -vs;
        end
        n_sum_x = hc - vs + 65'sd536870912;
        n_sum_y = hs + vc + 65'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_idx <= r_g_cnt;
            r_c1_rx  <= n_sum_x[64:30];
            r_c1_ry  <= n_sum_y[64:30];
            r_c1_px  <= r_g_px;
            r_c1_py  <= r_g_py;
        end
    end

    assign n_ox = 36'(r_c1_rx) + 36'(r_c1_px);
    assign n_oy = 36'(r_c1_ry) + 36'(r_c1_py);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.corner_index <= r_c1_idx;
            r_out.last_corner  <= (r_c1_idx == LAST_CORNER);
            if (n_ox[35:31] == {5{n_ox[35]}}) begin
                r_out.corner_x <= n_ox[31:0];
            end else begin
                r_out.corner_x <= n_ox[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            if (n_oy[35:31] == {5{n_oy[35]}}) begin
                r_out.corner_y <= n_oy[31:0];
            end else begin
                r_out.corner_y <= n_oy[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
    end

    // control: valid bits and the serialiser count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_m_valid   <= 1'b0;
            r_g_valid   <= 1'b0;
            r_g_cnt     <= '0;
            r_c1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= i_valid;
                r_m_valid  <= cd_valid;
                r_g_valid  <= r_m_valid;
                r_g_cnt    <= '0;
            end else if (en && r_g_valid) begin
                r_g_cnt <= r_g_cnt + 2'd1;
            end
            if (en) begin
                r_c1_valid  <= r_g_valid;
                r_out_valid <= r_c1_valid;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_corner = r_out;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the oriented box corner block: random and directed items checked per corner
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obc_pkg::*;

    localparam int          ANGLE_BITS  = 16;
    localparam int          ROT_STEPS   = 24;
    localparam longint      ROT_GAIN    = 64'sd652032874;
    localparam longint      UNIT_Q30    = 64'sd1 << 30;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          SETTLE_CYC  = 20;
    localparam logic [15:0] FACTOR_BOOT = 16'd6554;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam longint ROT_ATAN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_obc_in     i_item     = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_obc_out    o_corner;

    t_obc_in     pending_q[$];
    t_obc_out    corner_expect_q[$];
    logic [15:0] extent_now = FACTOR_BOOT;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          gap_left    = 0;
    int          burst_left  = 0;
    int          stall_mode  = 0;
    int          mode_left   = 0;
    int          run_left    = 0;

    oriented_box_corners #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_corner   (o_corner)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_unit(longint val);
        if (val > UNIT_Q30) return UNIT_Q30;
        if (val < -UNIT_Q30) return -UNIT_Q30;
        return val;
    endfunction

    function automatic logic [31:0] sat_q16(longint val);
        if (val > 64'sd2147483647) return 32'h7fff_ffff;
        if (val < -64'sd2147483648) return 32'h8000_0000;
        return val[31:0];
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] ang, output longint c,
                                          output longint s);
        logic [31:0] turn;
        logic [31:0] keep;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        keep = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
        turn = {ang, 16'h0000} & keep;
        z = longint'({2'b00, turn[29:0]});
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ATAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ATAN[i];
            end
        end
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c = clamp_unit(c);
        s = clamp_unit(s);
    endfunction

    // four corners in line loop order for one accepted beat
    function automatic void predict_corners(t_obc_in it);
        longint   h;
        longint   v;
        longint   c;
        longint   s;
        longint   cx;
        longint   cy;
        longint   rx;
        longint   ry;
        t_obc_out exp_c;
        h = (longint'($signed(it.scale_x)) * longint'(extent_now)) >>> 16;
        v = (longint'($signed(it.scale_y)) * longint'(extent_now)) >>> 16;
        angle_sin_cos(it.angle, c, s);
        for (int k = 0; k < 4; k++) begin
            cx = (k == 0 || k == 3) ? -h : h;
            cy = (k < 2) ? -v : v;
            rx = (cx * c - cy * s + (64'sd1 <<< 29)) >>> 30;
            ry = (cx * s + cy * c + (64'sd1 <<< 29)) >>> 30;
            exp_c.corner_index = 2'(k);
            exp_c.corner_x     = sat_q16(rx + longint'($signed(it.pos_x)));
            exp_c.corner_y     = sat_q16(ry + longint'($signed(it.pos_y)));
            exp_c.last_corner  = (2'(k) == LAST_CORNER);
            corner_expect_q.push_back(exp_c);
        end
    endfunction

    task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic t_obc_in make_box(logic [31:0] px, logic [31:0] py, logic [31:0] sx,
                                         logic [31:0] sy, logic [15:0] ang);
        t_obc_in it;
        it.pos_x   = px;
        it.pos_y   = py;
        it.scale_x = sx;
        it.scale_y = sy;
        it.angle   = ang;
        return it;
    endfunction

    function automatic t_obc_in random_box();
        t_obc_in it;
        int      kind;
        kind = $urandom_range(0, 9);
        it.pos_x   = $urandom();
        it.pos_y   = $urandom();
        it.scale_x = $urandom();
        it.scale_y = $urandom();
        it.angle   = $urandom_range(0, 65535);
        if (kind < 6) begin
            // mostly in-range boxes so the corners are not all pinned
            it.pos_x   = $signed(it.pos_x) >>> $urandom_range(1, 16);
            it.pos_y   = $signed(it.pos_y) >>> $urandom_range(1, 16);
            it.scale_x = $signed(it.scale_x) >>> $urandom_range(0, 14);
            it.scale_y = $signed(it.scale_y) >>> $urandom_range(0, 14);
        end else if (kind == 9) begin
            it.pos_x = $urandom_range(0, 1) ? 32'h7fff_0000 + $urandom_range(0, 65535)
                                            : 32'h8000_0000 + $urandom_range(0, 65535);
            it.pos_y = $urandom_range(0, 1) ? 32'h7fff_0000 + $urandom_range(0, 65535)
                                            : 32'h8000_0000 + $urandom_range(0, 65535);
        end
        if ($urandom_range(0, 7) == 0)
            it.angle = 16'($urandom_range(0, 3) << 14) + 16'($signed($urandom_range(0, 2)) - 1);
        return it;
    endfunction

    // wait for the sender and the result store to empty, then let the pipe settle
    task automatic drain_all();
        @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || corner_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic set_extent(logic [15:0] val);
        drain_all();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        extent_now = val;
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++)
            pending_q.push_back(random_box());
    endtask

    // driver: input beats in bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_corners(i_item);
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    i_item  <= pending_q.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: free running, random, or long runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (run_left == 0) begin
                        i_stall  <= ~i_stall;
                        run_left <= $urandom_range(1, 12);
                    end else begin
                        run_left <= run_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : corner_monitor
        t_obc_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (corner_expect_q.size() == 0) begin
                flag_error("unexpected corner beat", o_corner.corner_x, '0);
            end else begin
                want = corner_expect_q.pop_front();
                if (o_corner.corner_index !== want.corner_index)
                    flag_error("corner_index", 32'(o_corner.corner_index),
                               32'(want.corner_index));
                if (o_corner.corner_x !== want.corner_x)
                    flag_error("corner_x", o_corner.corner_x, want.corner_x);
                if (o_corner.corner_y !== want.corner_y)
                    flag_error("corner_y", o_corner.corner_y, want.corner_y);
                if (o_corner.last_corner !== want.last_corner)
                    flag_error("last_corner", 32'(o_corner.last_corner),
                               32'(want.last_corner));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // directed boxes at the reset extent factor
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0, 32'h0, 16'h0000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h0000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h4000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h8000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'hc000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'hffff));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h2000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h3fff));
        pending_q.push_back(make_box(32'h0001_0000, 32'hffff_0000, 32'hfffe_0000,
                                     32'hffff_0000, 16'h1234));
        pending_q.push_back(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'h7fff_ffff, 16'h0000));
        pending_q.push_back(make_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                     32'h7fff_ffff, 16'h0000));
        pending_q.push_back(make_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                     32'h8000_0000, 16'h6000));
        pending_q.push_back(make_box(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                     32'h7fff_ffff, 16'ha000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 16'he000));
        pending_q.push_back(make_box(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 16'h0001));
        pending_q.push_back(make_box(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                                     32'h0000_0001, 16'h8001));
        pending_q.push_back(make_box(32'h7fff_0000, 32'h0, 32'h0100_0000, 32'h0100_0000,
                                     16'h0000));
        pending_q.push_back(make_box(32'h0, 32'h8001_0000, 32'h0100_0000, 32'h0100_0000,
                                     16'h4000));
        pending_q.push_back(make_box(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                                     32'h5555_5555, 16'h5555));
        pending_q.push_back(make_box(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555,
                                     32'haaaa_aaaa, 16'haaaa));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_extent(16'hffff);
        queue_random(60);
        set_extent(16'h0000);
        queue_random(20);
        set_extent(16'($urandom_range(0, 65535)));
        queue_random(60);
        set_extent(16'h0001);
        queue_random(60);
        set_extent(16'($urandom_range(0, 65535)));
        queue_random(40);
        drain_all();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: oriented_box_corners.f
rtl/obc_pkg.sv
rtl/obc_cordic.sv
rtl/oriented_box_corners.sv
tb/sv/tb.sv
